// ===== rtl/sbm_pkg.sv =====
// Shared types and constants for the spectrum band meter.
// No dependencies; imported by every module of the block except sbm_ram.
package sbm_pkg;

    localparam int BANDS_DEF     = 256;
    localparam int BIN_WIDTH_DEF = 24;

    localparam int BAND_W     = 8;
    localparam int DB_W       = 16;
    localparam int HDS_W      = 10;
    localparam int RSH_W      = 3;
    localparam int EXP_W      = 6;
    localparam int MANT_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DEPTH  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PSCALE  = 2'd3;

    localparam logic signed [DB_W-1:0] FLOOR_RESET   = -16'sd30720;
    localparam logic [HDS_W-1:0]       DECAY_RESET   = 10'd23;
    localparam logic [RSH_W-1:0]       RELEASE_RESET = 3'd2;
    localparam logic [EXP_W-1:0]       PSCALE_RESET  = 6'd26;

    localparam logic signed [DB_W-1:0] DB_MIN = 16'sh8000;
    localparam logic signed [DB_W-1:0] DB_MAX = 16'sh7fff;

    // 256 * 10 * log10(2) in Q16
    localparam int             DBK_W           = 26;
    localparam logic [DBK_W-1:0] DB_PER_LOG2_Q16 = 26'd50504453;

    typedef struct packed {
        logic signed [DB_W-1:0] floor_level;
        logic [HDS_W-1:0]       hold_decay_step;
        logic [RSH_W-1:0]       release_shift;
        logic [EXP_W-1:0]       power_scale_shift;
    } t_cfg;

    typedef struct packed {
        logic                   valid;
        logic [BAND_W-1:0]      band;
        logic signed [DB_W-1:0] db;
    } t_db_res;

    typedef struct packed {
        logic [BAND_W-1:0]      band;
        logic signed [DB_W-1:0] level;
        logic signed [DB_W-1:0] hold;
        logic signed [DB_W-1:0] instant;
    } t_meter;

    typedef struct packed {
        logic              zero;
        logic [EXP_W-1:0]  exp;
        logic [BAND_W-1:0] band;
    } t_lg_ctl;

endpackage

// ===== rtl/sbm_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
// Read of an address written in the same cycle returns the old word.
module sbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sbm_out_fifo.sv =====
// Result word FIFO between the band update and the master stream side.
// Uses sbm_pkg; overflow is prevented upstream by slot reservation.
module sbm_out_fifo import sbm_pkg::*; #(
    parameter int WIDTH = 56,
    parameter int DEPTH = OUT_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/sbm_db_conv.sv =====
// Band power to 1/256 dB pipeline: leading-one search, normalize, 16 squaring
// stages for the log2 fraction, scale by 10*log10(2), round and saturate. Uses sbm_pkg.
module sbm_db_conv import sbm_pkg::*; #(
    parameter int BANDS = BANDS_DEF,
    parameter int PWR_W = 2 * BIN_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BAND_W-1:0] i_band,
    input  logic [PWR_W-1:0]  i_pow,
    input  logic [EXP_W-1:0]  i_pscale,
    output logic              o_drop,
    output t_db_res           o_res
);

    localparam int NG      = (PWR_W + 7) / 8;
    localparam int GI_W    = $clog2(NG);
    localparam int PAD_W   = NG * 8;
    localparam int EXT_W   = PAD_W + MANT_W - 1;
    localparam int DIFF_W  = 8;
    localparam int L_W     = DIFF_W + FRAC_W;
    localparam int PROD_W  = L_W + DBK_W;
    localparam int RND_W   = PROD_W - 32;
    localparam int DB_MAG  = 32767;
    localparam logic [PROD_W-1:0] RND_HALF = {{(PROD_W - 32){1'b0}}, 1'b1, 31'b0};

    // leading one per byte group
    logic              w_in_range;
    logic [PAD_W-1:0]  w_pad;
    logic [NG-1:0]     w_nz;
    logic [2:0]        w_pos_a [NG];
    logic              r_a_valid;
    logic [BAND_W-1:0] r_a_band;
    logic [PAD_W-1:0]  r_a_pow;
    logic [NG-1:0]     r_a_nz;
    logic [2:0]        r_a_pos [NG];

    assign w_in_range = (32'(i_band) < 32'(BANDS));
    assign o_drop     = i_valid && !w_in_range;
    assign w_pad      = PAD_W'(i_pow);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_nz[g]    = |w_pad[g*8 +: 8];
            w_pos_a[g] = '0;
            for (int j = 0; j < 8; j++) begin
                if (w_pad[g*8 + j]) begin
                    w_pos_a[g] = 3'(j);
                end
            end
        end
    end

    // exponent
    logic [GI_W-1:0]   w_grp;
    logic [2:0]        w_pos_b;
    t_lg_ctl           w_ctl_b;
    logic              r_b_valid;
    t_lg_ctl           r_b_ctl;
    logic [PAD_W-1:0]  r_b_pow;

    always_comb begin
        w_grp   = '0;
        w_pos_b = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_a_nz[g]) begin
                w_grp   = GI_W'(g);
                w_pos_b = r_a_pos[g];
            end
        end
        w_ctl_b.zero = !(|r_a_nz);
        w_ctl_b.exp  = EXP_W'({w_grp, w_pos_b});
        w_ctl_b.band = r_a_band;
    end

    // mantissa normalize and squaring chain
    logic [EXT_W-1:0]    w_ext;
    logic [MANT_W-1:0]   w_mant;
    logic                r_v [FRAC_W+1];
    logic [MANT_W-1:0]   r_m [FRAC_W+1];
    logic [FRAC_W-1:0]   r_f [FRAC_W+1];
    t_lg_ctl             r_c [FRAC_W+1];
    logic [2*MANT_W-1:0] w_sq [FRAC_W];
    logic                w_bit [FRAC_W];
    logic [MANT_W-1:0]   n_m [FRAC_W];

    assign w_ext  = {r_b_pow, {(MANT_W - 1){1'b0}}};
    assign w_mant = MANT_W'(w_ext >> r_b_ctl.exp);

    always_comb begin
        for (int k = 0; k < FRAC_W; k++) begin
            w_sq[k]  = r_m[k] * r_m[k];
            w_bit[k] = w_sq[k][2*MANT_W-1];
            n_m[k]   = w_bit[k] ? w_sq[k][2*MANT_W-1:MANT_W]
                                : w_sq[k][2*MANT_W-2:MANT_W-1];
        end
    end

    // scale to dB
    logic signed [DIFF_W-1:0] w_ediff;
    logic [L_W-1:0]           w_l;
    logic [L_W-1:0]           w_lmag;
    logic [PROD_W-1:0]        w_prod;
    logic                     r_d_valid;
    logic                     r_d_neg;
    logic                     r_d_zero;
    logic [BAND_W-1:0]        r_d_band;
    logic [PROD_W-1:0]        r_d_prod;

    assign w_ediff = $signed({{(DIFF_W - EXP_W){1'b0}}, r_c[FRAC_W].exp})
                   - $signed({{(DIFF_W - EXP_W){1'b0}}, i_pscale});
    assign w_l     = {w_ediff, r_f[FRAC_W]};
    assign w_lmag  = w_ediff[DIFF_W-1] ? (~w_l + 1'b1) : w_l;
    assign w_prod  = w_lmag * DB_PER_LOG2_Q16;

    // round half away from zero, saturate
    logic [PROD_W-1:0]      w_rsum;
    logic [RND_W-1:0]       w_rnd;
    logic [RND_W-1:0]       w_rneg;
    logic signed [DB_W-1:0] w_db;
    logic                   r_res_valid;
    logic [BAND_W-1:0]      r_res_band;
    logic signed [DB_W-1:0] r_res_db;

    assign w_rsum = r_d_prod + RND_HALF;
    assign w_rnd  = w_rsum[PROD_W-1:32];
    assign w_rneg = ~w_rnd + 1'b1;

    always_comb begin
        if (r_d_zero) begin
            w_db = DB_MIN;
        end else if (!r_d_neg) begin
            w_db = (w_rnd > RND_W'(DB_MAG)) ? DB_MAX : w_rnd[DB_W-1:0];
        end else begin
            w_db = (w_rnd > RND_W'(DB_MAG + 1)) ? DB_MIN : w_rneg[DB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_res_valid <= 1'b0;
            for (int k = 0; k <= FRAC_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_a_valid   <= i_valid && w_in_range;
            r_b_valid   <= r_a_valid;
            r_v[0]      <= r_b_valid;
            for (int k = 0; k < FRAC_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_d_valid   <= r_v[FRAC_W];
            r_res_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_band <= i_band;
        r_a_pow  <= w_pad;
        r_a_nz   <= w_nz;
        for (int g = 0; g < NG; g++) begin
            r_a_pos[g] <= w_pos_a[g];
        end
        r_b_ctl  <= w_ctl_b;
        r_b_pow  <= r_a_pow;
        r_m[0]   <= w_mant;
        r_f[0]   <= '0;
        r_c[0]   <= r_b_ctl;
        for (int k = 0; k < FRAC_W; k++) begin
            r_m[k+1] <= n_m[k];
            r_f[k+1] <= {r_f[k][FRAC_W-2:0], w_bit[k]};
            r_c[k+1] <= r_c[k];
        end
        r_d_neg    <= w_ediff[DIFF_W-1];
        r_d_zero   <= r_c[FRAC_W].zero;
        r_d_band   <= r_c[FRAC_W].band;
        r_d_prod   <= w_prod;
        r_res_band <= r_d_band;
        r_res_db   <= w_db;
    end

    assign o_res = {r_res_valid, r_res_band, r_res_db};

endmodule

// ===== rtl/sbm_band_upd.sv =====
// Per-band level and hold read-modify-write around one sbm_ram.
// Clears the RAM to the reset floor after reset; forwards back-to-back same-band updates.
module sbm_band_upd import sbm_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_db_res i_res,
    output logic    o_busy,
    output logic    o_valid,
    output t_meter  o_meter
);

    localparam int AW = $clog2(BANDS);
    localparam int RW = 2 * DB_W;

    logic                   r_clr_busy;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_u_valid;
    logic [BAND_W-1:0]      r_u_band;
    logic signed [DB_W-1:0] r_u_db;
    logic                   r_fwd_valid;
    logic [BAND_W-1:0]      r_fwd_band;
    logic [RW-1:0]          r_fwd_data;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [RW-1:0]          w_wdata;
    logic [RW-1:0]          w_rdata;
    logic [RW-1:0]          w_cur;
    logic signed [DB_W-1:0] w_lvl, w_hld, w_lvl_n, w_hld_n, w_hlow;
    logic signed [DB_W:0]   w_ldiff, w_lstep, w_lsum, w_hdec;

    sbm_ram #(
        .WIDTH (RW),
        .DEPTH (BANDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(i_res.band)),
        .o_rdata (w_rdata)
    );

    // RAM read of the previous update's band landed before its write
    assign w_cur = (r_fwd_valid && (r_fwd_band == r_u_band)) ? r_fwd_data : w_rdata;
    assign w_lvl = w_cur[DB_W-1:0];
    assign w_hld = w_cur[RW-1:DB_W];

    always_comb begin
        w_ldiff = {r_u_db[DB_W-1], r_u_db} - {w_lvl[DB_W-1], w_lvl};
        w_lstep = w_ldiff >>> i_cfg.release_shift;
        w_lsum  = {w_lvl[DB_W-1], w_lvl} + w_lstep;
        w_lvl_n = (r_u_db > w_lvl) ? r_u_db : w_lsum[DB_W-1:0];
        w_hdec  = {w_hld[DB_W-1], w_hld} - {{(DB_W + 1 - HDS_W){1'b0}}, i_cfg.hold_decay_step};
        w_hlow  = (w_hdec > $signed({i_cfg.floor_level[DB_W-1], i_cfg.floor_level}))
                ? w_hdec[DB_W-1:0] : i_cfg.floor_level;
        w_hld_n = (w_lvl_n > w_hld) ? w_lvl_n : w_hlow;
    end

    assign w_we    = r_clr_busy || r_u_valid;
    assign w_waddr = r_clr_busy ? r_clr_addr : AW'(r_u_band);
    assign w_wdata = r_clr_busy ? {FLOOR_RESET, FLOOR_RESET} : {w_hld_n, w_lvl_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_u_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(BANDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_u_valid   <= i_res.valid;
            r_fwd_valid <= r_u_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_band   <= i_res.band;
        r_u_db     <= i_res.db;
        r_fwd_band <= r_u_band;
        r_fwd_data <= {w_hld_n, w_lvl_n};
    end

    assign o_busy          = r_clr_busy;
    assign o_valid         = r_u_valid;
    assign o_meter.band    = r_u_band;
    assign o_meter.level   = w_lvl_n;
    assign o_meter.hold    = w_hld_n;
    assign o_meter.instant = r_u_db;

endmodule

// ===== rtl/spectrum_band_meter_peak_hold_unit.sv =====
// Spectrum band meter with peak hold: bin power, band maximum, dB meter and hold.
// Throughput: one bin word per cycle while ready; ready drops while 32 band results are owed
// to the result FIFO (reserved on each last bin, freed as words leave or out-of-range bands drop)
// Reset: synchronous, clears control and config; then a pass over all BANDS entries (256 by default)
// writes the floor into the band RAM with o_s_tready low. Config writes are always taken.
module spectrum_band_meter_peak_hold_unit import sbm_pkg::*; #(
    parameter int BANDS     = BANDS_DEF,
    parameter int BIN_WIDTH = BIN_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((2 * BIN_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata, // bin_real, bin_imag
    input  logic [BAND_W-1:0]                     i_s_tuser,  // band_index
    input  logic                                  i_s_tlast,  // last_bin
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [3*DB_W-1:0]                     o_m_tdata,  // level_db, hold_db, instant_db
    output logic [BAND_W-1:0]                     o_m_tuser,  // out_band
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data
);

    localparam int PWR_W = 2 * BIN_WIDTH;
    localparam int CRD_W = $clog2(OUT_DEPTH + 1);

    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLOOR:   n_cfg.floor_level       = i_cfg_data;
                CFG_DECAY:   n_cfg.hold_decay_step   = i_cfg_data[HDS_W-1:0];
                CFG_RELEASE: n_cfg.release_shift     = i_cfg_data[RSH_W-1:0];
                CFG_PSCALE:  n_cfg.power_scale_shift = i_cfg_data[EXP_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // bin power and band maximum
    logic [BIN_WIDTH-1:0] w_re, w_im, w_re_mag, w_im_mag;
    logic [PWR_W-1:0]     w_re_sq, w_im_sq, w_pow, w_max;
    logic                 r_sq_valid, r_sq_last;
    logic [PWR_W-1:0]     r_sq_re, r_sq_im;
    logic [BAND_W-1:0]    r_sq_band;
    logic [PWR_W-1:0]     r_run_max, n_run_max;
    logic                 r_pk_valid;
    logic [PWR_W-1:0]     r_pk_pow;
    logic [BAND_W-1:0]    r_pk_band;

    assign w_re     = i_s_tdata[BIN_WIDTH-1:0];
    assign w_im     = i_s_tdata[2*BIN_WIDTH-1:BIN_WIDTH];
    assign w_re_mag = w_re[BIN_WIDTH-1] ? (~w_re + 1'b1) : w_re;
    assign w_im_mag = w_im[BIN_WIDTH-1] ? (~w_im + 1'b1) : w_im;
    assign w_re_sq  = w_re_mag * w_re_mag;
    assign w_im_sq  = w_im_mag * w_im_mag;
    assign w_pow    = r_sq_re + r_sq_im;
    assign w_max    = (w_pow > r_run_max) ? w_pow : r_run_max;

    always_comb begin
        n_run_max = r_run_max;
        if (r_sq_valid) begin
            n_run_max = r_sq_last ? '0 : w_max;
        end
    end

    // result slot reservation
    logic             w_in_acc, w_out_acc, w_drop, w_busy;
    logic [CRD_W-1:0] r_credit, n_credit;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;
    assign n_credit  = r_credit + CRD_W'(w_in_acc && i_s_tlast)
                     - CRD_W'(w_out_acc) - CRD_W'(w_drop);
    assign o_s_tready = !w_busy && (r_credit < CRD_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_level       <= FLOOR_RESET;
            r_cfg.hold_decay_step   <= DECAY_RESET;
            r_cfg.release_shift     <= RELEASE_RESET;
            r_cfg.power_scale_shift <= PSCALE_RESET;
            r_sq_valid              <= 1'b0;
            r_pk_valid              <= 1'b0;
            r_run_max               <= '0;
            r_credit                <= '0;
        end else begin
            r_cfg      <= n_cfg;
            r_sq_valid <= w_in_acc;
            r_pk_valid <= r_sq_valid && r_sq_last;
            r_run_max  <= n_run_max;
            r_credit   <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_re   <= w_re_sq;
        r_sq_im   <= w_im_sq;
        r_sq_band <= i_s_tuser;
        r_sq_last <= i_s_tlast;
        r_pk_pow  <= w_max;
        r_pk_band <= r_sq_band;
    end

    t_db_res w_res;
    logic    w_upd_valid;
    t_meter  w_meter;
    t_meter  w_out;

    sbm_db_conv #(
        .BANDS (BANDS),
        .PWR_W (PWR_W)
    ) u_db_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_pk_valid),
        .i_band   (r_pk_band),
        .i_pow    (r_pk_pow),
        .i_pscale (r_cfg.power_scale_shift),
        .o_drop   (w_drop),
        .o_res    (w_res)
    );

    sbm_band_upd #(
        .BANDS (BANDS)
    ) u_band_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_res   (w_res),
        .o_busy  (w_busy),
        .o_valid (w_upd_valid),
        .o_meter (w_meter)
    );

    sbm_out_fifo #(
        .WIDTH ($bits(t_meter)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_upd_valid),
        .i_data  (w_meter),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    assign o_m_tdata = {w_out.instant, w_out.hold, w_out.level};
    assign o_m_tuser = w_out.band;

endmodule

// ===== rtl/sbm_checker.sv =====
// Port-level checks for the spectrum band meter, bound to the top level.
// Uses sbm_pkg for field widths.
module sbm_checker import sbm_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [3*DB_W-1:0]   o_m_tdata,
    input logic [BAND_W-1:0]   o_m_tuser
);

    a_out_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid right after reset");

    a_in_blocked_for_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("bin words taken before the band RAM clear");

    a_out_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed or dropped");

    a_level_not_below_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $signed(o_m_tdata[DB_W-1:0]) >= $signed(o_m_tdata[3*DB_W-1:2*DB_W]))
        else $error("smoothed level below instant level");

    a_band_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tuser) < 32'(BANDS)))
        else $error("result for a band outside the table");

endmodule

bind spectrum_band_meter_peak_hold_unit sbm_checker #(
    .BANDS (BANDS)
) u_sbm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== dv/sbm_meter_checker.sv =====
// Checker for the spectrum band meter: tracks register writes and bin words, predicts each
// band update (dB conversion, level release, peak hold) and compares result words.
// Depends on sbm_pkg for widths, register indexes and reset values.
module sbm_meter_checker import sbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [47:0]           i_s_tdata,
    input  logic [BAND_W-1:0]     i_s_tuser,
    input  logic                  i_s_tlast,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [3*DB_W-1:0]     i_m_tdata,
    input  logic [BAND_W-1:0]     i_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_owed,
    output int                    o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [DB_W-1:0] floor_lvl;
    logic [HDS_W-1:0]       decay_step;
    logic [RSH_W-1:0]       rel_shift;
    logic [EXP_W-1:0]       pwr_shift;
    logic [47:0]            peak_pwr;
    logic signed [DB_W-1:0] levels [BANDS_DEF];
    logic signed [DB_W-1:0] holds [BANDS_DEF];
    t_meter                 owed_updates [$];

    initial begin
        o_owed = 0;
        o_mismatches = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    function automatic logic signed [DB_W-1:0] db_of_power(input logic [63:0] pwr);
        int                unsigned msb;
        int                i;
        logic [63:0]       mant;
        logic [FRAC_W-1:0] frac;
        longint            log2q;
        longint            prod;
        longint            rnd;
        if (pwr == 0)
            return DB_MIN;
        msb = 0;
        for (i = 0; i < 64; i++)
            if (pwr[i])
                msb = i;
        mant = (msb <= 31) ? (pwr << (31 - msb)) : (pwr >> (msb - 31));
        frac = '0;
        for (i = 0; i < FRAC_W; i++) begin
            mant = (mant * mant) >> 31;
            frac = {frac[FRAC_W-2:0], 1'b0};
            if (mant >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        log2q = longint'(msb) * 65536 + longint'(frac) - longint'(pwr_shift) * 65536;
        prod = log2q * longint'(DB_PER_LOG2_Q16);
        if (prod >= 0)
            rnd = (prod + 64'sd2147483648) >>> 32;
        else
            rnd = -((-prod + 64'sd2147483648) >>> 32);
        if (rnd > 32767)
            return DB_MAX;
        if (rnd < -32768)
            return DB_MIN;
        return rnd[DB_W-1:0];
    endfunction

    task automatic take_bin();
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [23:0]        mre;
        logic [23:0]        mim;
        logic [47:0]        pwr;
        t_meter             upd;
        int                 inst;
        int                 lvl;
        int                 hld;
        int                 lowered;
        re  = i_s_tdata[23:0];
        im  = i_s_tdata[47:24];
        mre = re[23] ? -re : re;
        mim = im[23] ? -im : im;
        pwr = 48'(mre) * 48'(mre) + 48'(mim) * 48'(mim);
        if (pwr > peak_pwr)
            peak_pwr = pwr;
        if (!i_s_tlast)
            return;
        upd.instant = db_of_power(64'(peak_pwr));
        peak_pwr = '0;
        inst = upd.instant;
        lvl = levels[i_s_tuser];
        if (inst > lvl)
            lvl = inst;
        else
            lvl = lvl + ((inst - lvl) >>> rel_shift);
        hld = holds[i_s_tuser];
        if (lvl > hld) begin
            hld = lvl;
        end else begin
            lowered = hld - int'(decay_step);
            hld = (lowered > floor_lvl) ? lowered : floor_lvl;
        end
        levels[i_s_tuser] = lvl[DB_W-1:0];
        holds[i_s_tuser]  = hld[DB_W-1:0];
        upd.band  = i_s_tuser;
        upd.level = lvl[DB_W-1:0];
        upd.hold  = hld[DB_W-1:0];
        owed_updates.push_back(upd);
    endtask

    task automatic check_word();
        t_meter want;
        if (owed_updates.size() == 0) begin
            report_mismatch($sformatf("unexpected result word, band %0d", i_m_tuser));
            return;
        end
        want = owed_updates.pop_front();
        if (i_m_tuser !== want.band)
            report_mismatch($sformatf("band got %0d want %0d", i_m_tuser, want.band));
        if (i_m_tdata[15:0] !== want.level)
            report_mismatch($sformatf("band %0d level got %0d want %0d", want.band,
                                      $signed(i_m_tdata[15:0]), want.level));
        if (i_m_tdata[31:16] !== want.hold)
            report_mismatch($sformatf("band %0d hold got %0d want %0d", want.band,
                                      $signed(i_m_tdata[31:16]), want.hold));
        if (i_m_tdata[47:32] !== want.instant)
            report_mismatch($sformatf("band %0d instant got %0d want %0d", want.band,
                                      $signed(i_m_tdata[47:32]), want.instant));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            floor_lvl  = FLOOR_RESET;
            decay_step = DECAY_RESET;
            rel_shift  = RELEASE_RESET;
            pwr_shift  = PSCALE_RESET;
            peak_pwr   = '0;
            for (int b = 0; b < BANDS_DEF; b++) begin
                levels[b] = FLOOR_RESET;
                holds[b]  = FLOOR_RESET;
            end
            owed_updates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FLOOR:   floor_lvl  = i_cfg_data;
                    CFG_DECAY:   decay_step = i_cfg_data[HDS_W-1:0];
                    CFG_RELEASE: rel_shift  = i_cfg_data[RSH_W-1:0];
                    CFG_PSCALE:  pwr_shift  = i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                take_bin();
            if (i_m_tvalid && i_m_tready)
                check_word();
        end
        o_owed = owed_updates.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the spectrum band meter bench: clock, reset and stimulus (directed, then random
// band sequences over several register settings). Checking is done in sbm_meter_checker.
// Depends on sbm_pkg and the spectrum_band_meter_peak_hold_unit RTL.
module testbench import sbm_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [47:0]           i_s_tdata;   // bin_real, bin_imag
    logic [BAND_W-1:0]     i_s_tuser;   // band_index
    logic                  i_s_tlast;   // last_bin
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [3*DB_W-1:0]     o_m_tdata;   // level_db, hold_db, instant_db
    logic [BAND_W-1:0]     o_m_tuser;   // out_band
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    owed;
    int                    mismatches;
    logic                  calm;
    int                    bins_sent;

    spectrum_band_meter_peak_hold_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sbm_meter_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_owed       (owed),
        .o_mismatches (mismatches)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 15);
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_bin(input logic signed [23:0] re, input logic signed [23:0] im,
                            input logic [BAND_W-1:0] band, input logic last);
        while (!calm && $urandom_range(99) < 15) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 48'({$urandom, $urandom});
            i_s_tuser  <= BAND_W'($urandom);
            i_s_tlast  <= 1'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {im, re};
        i_s_tuser  <= band;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        bins_sent++;
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // meter must be drained first
    task automatic set_meter(input logic signed [DB_W-1:0] floor_db, input logic [HDS_W-1:0] decay,
                             input logic [RSH_W-1:0] rel, input logic [EXP_W-1:0] pscale);
        put_register(CFG_FLOOR, floor_db);
        put_register(CFG_DECAY, CFG_DATA_W'(decay));
        put_register(CFG_RELEASE, CFG_DATA_W'(rel));
        put_register(CFG_PSCALE, CFG_DATA_W'(pscale));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (owed != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] pick_part();
        logic signed [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(7))
            0:       return '0;
            1:       return 24'sh800000;
            2:       return 24'sh7fffff;
            3, 4:    return v;
            default: return v >>> $urandom_range(23);
        endcase
    endfunction

    task automatic random_settings(input int mode);
        logic signed [DB_W-1:0] fl;
        logic [HDS_W-1:0]       dec;
        logic [RSH_W-1:0]       rel;
        logic [EXP_W-1:0]       psc;
        int                     t;
        t = $urandom_range(32768);
        fl  = 16'(-t);
        dec = HDS_W'($urandom);
        rel = RSH_W'($urandom);
        psc = ($urandom_range(1) == 0) ? EXP_W'($urandom_range(40, 18)) : EXP_W'($urandom);
        if (mode == 0 || (mode > 1 && $urandom_range(3) == 0)) begin
            fl = DB_MIN;
            dec = '0;
        end
        if (mode == 1 || (mode > 1 && $urandom_range(3) == 0)) begin
            fl = '0;
            dec = '1;
        end
        if (mode == 0)
            {rel, psc} = '0;
        if (mode == 1)
            {rel, psc} = '1;
        set_meter(fl, dec, rel, psc);
    endtask

    // one band: mostly well-formed, sometimes stray tags or a missing last bin
    task automatic send_band();
        int              nbins;
        int              k;
        int              pick;
        logic [BAND_W-1:0] band;
        logic [BAND_W-1:0] tag;
        logic            quiet;
        logic            closed;
        pick = $urandom_range(7);
        if ($urandom_range(9) < 8)
            band = (pick >= 4) ? BAND_W'(255 - (pick - 4)) : BAND_W'(pick);
        else
            band = BAND_W'($urandom_range(255));
        nbins  = ($urandom_range(3) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
        quiet  = ($urandom_range(9) == 0);
        closed = ($urandom_range(19) != 0);
        for (k = 0; k < nbins; k++) begin
            tag = ($urandom_range(9) == 0) ? BAND_W'($urandom) : band;
            send_bin(quiet ? 24'sd0 : pick_part(), quiet ? 24'sd0 : pick_part(), tag,
                     closed && (k == nbins - 1));
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FLOOR;
        i_cfg_data  = '0;
        calm        = 1'b0;
        bins_sent   = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero power, full scale, stray tags, smallest powers, release
        send_bin(24'sd0, 24'sd0, 8'd0, 1'b1);
        send_bin(24'sh800000, 24'sh800000, 8'd255, 1'b1);
        send_bin(24'sh7fffff, -24'sd1, 8'd255, 1'b1);
        send_bin(24'sd100, 24'sd200, 8'd7, 1'b0);
        send_bin(24'sh800000, 24'sd0, 8'd3, 1'b0);
        send_bin(24'sd5, 24'sd5, 8'd7, 1'b1);
        send_bin(24'sd1, 24'sd0, 8'd7, 1'b1);
        send_bin(24'sd0, 24'sd1, 8'd7, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd255, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd255, 1'b1);
        send_bin(24'sd0, 24'sh800000, 8'd128, 1'b1);
        send_bin(24'sd4095, -24'sd4096, 8'd128, 1'b1);
        drain();

        // top saturation, floor above stored holds, fastest hold fall
        set_meter(16'sd0, 10'd1023, 3'd7, 6'd0);
        send_bin(24'sh7fffff, 24'sh7fffff, 8'd1, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd1, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd0, 1'b1);
        send_bin(24'sd123, 24'sd456, 8'd255, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd1, 1'b1);
        drain();

        // bottom saturation, no release smoothing, frozen hold
        set_meter(DB_MIN, 10'd0, 3'd0, 6'd63);
        send_bin(24'sd1, 24'sd0, 8'd2, 1'b1);
        send_bin(24'sh800000, 24'sh800000, 8'd2, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd2, 1'b1);
        send_bin(24'sd0, 24'sd0, 8'd0, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_settings(ph);
            calm = (ph == 3);
            bins_sent = 0;
            while (bins_sent < 155)
                send_band();
            send_bin(pick_part(), pick_part(), BAND_W'($urandom), 1'b1);
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== spectrum_band_meter_peak_hold_unit.f =====
rtl/sbm_pkg.sv
rtl/sbm_ram.sv
rtl/sbm_out_fifo.sv
rtl/sbm_db_conv.sv
rtl/sbm_band_upd.sv
rtl/spectrum_band_meter_peak_hold_unit.sv
rtl/sbm_checker.sv
dv/sbm_meter_checker.sv
dv/testbench.sv
